// ----- design/ptet_pkg.sv -----
// Package for the periodic / one-shot event timer.
// Holds the slot record, result and control types, codes and defaults.
// No dependencies.
package ptet_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int MAX_RESULTS   = 16;

  // one_shot flag value that makes a slot deactivate after it fires
  localparam logic EVT_SINGLE = 1'b1;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_ADD     = 2'd1,
    ACT_DISABLE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH
  } state_t;

  // one timer slot as kept in the slot memory
  typedef struct packed {
    logic        one_shot;
    logic [31:0] period;
    logic [31:0] count;
    logic [7:0]  dest;
    logic [15:0] message;
  } slot_rec_t;

  // outcome of one tick applied to an active slot
  typedef struct packed {
    logic      fire;
    logic      keep_active;
    slot_rec_t rec_next;
  } slot_eval_t;

  typedef struct packed {
    logic        fired;
    logic [3:0]  fired_slot;
    logic [7:0]  dest;
    logic [15:0] message;
    logic        last;
  } res_t;

endpackage

// ----- design/ptet_if.sv -----
// Handshake channels of the event timer: request items in, result items out.
// Depends on nothing; payload widths are fixed.
interface ptet_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [3:0]  slot;
  logic [31:0] period;
  logic        one_shot;
  logic [7:0]  dest_id;
  logic [15:0] message_id;

  modport source (output valid, action, slot, period, one_shot, dest_id, message_id,
                  input ready);
  modport sink   (input valid, action, slot, period, one_shot, dest_id, message_id,
                  output ready);
endinterface

interface ptet_rsp_if;
  logic        valid;
  logic        ready;
  logic        fired;
  logic [3:0]  fired_slot;
  logic [7:0]  out_dest;
  logic [15:0] out_message;
  logic        last;

  modport source (output valid, fired, fired_slot, out_dest, out_message, last,
                  input ready);
  modport sink   (input valid, fired, fired_slot, out_dest, out_message, last,
                  output ready);
endinterface

// ----- design/periodic_oneshot_event_timer.sv -----
// Top level of the periodic / one-shot event timer: slot memory, scan control,
// pending result and output register.
// Depends on ptet_pkg, ptet_if (ptet_req_if, ptet_rsp_if) and ptet_slot_eval.
//
//  channel | dir | carries
//  --------+-----+------------------------------------------------------------
//  req     | in  | action, slot, period, one_shot, dest_id, message_id
//  rsp     | out | fired, fired_slot, out_dest, out_message, last
//
// Add and disable, and the unused action code, give one acknowledgement item.
// A tick reads the slot memory one slot per cycle, unless a stall holds the scan,
// through the registered read port, and writes the updated count back from the read data;
// a firing that waits on a stalled output register holds the scan.
// One firing is held back so the last one can carry last; an earlier one
// is pushed out when the next is found.
// Reset clears the active flags and control; slot memory is left as is.
module periodic_oneshot_event_timer #(
  parameter int NUM_SLOTS = ptet_pkg::NUM_SLOTS_DEF
) (
  input logic      clk,
  input logic      rst,
  ptet_req_if.sink   req,
  ptet_rsp_if.source rsp
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int NW = $clog2(ptet_pkg::MAX_RESULTS + 1);

  ptet_pkg::slot_rec_t mem [NUM_SLOTS];
  ptet_pkg::slot_rec_t rdata;
  logic [NUM_SLOTS-1:0] active;

  ptet_pkg::state_t state, state_next;
  logic [IW-1:0] proc_idx;
  logic [NW-1:0] nrep;
  ptet_pkg::res_t pend;
  logic pend_valid;
  ptet_pkg::res_t out_res;
  logic out_valid;

  ptet_pkg::slot_eval_t ev;

  logic req_acc, out_free, in_range, proc_last;
  logic fire_rep, stall, step;
  logic rd_en;
  logic [IW-1:0] rd_addr;
  logic out_load;
  ptet_pkg::res_t out_next;
  ptet_pkg::res_t cur_res;
  ptet_pkg::res_t ack_res;

  ptet_slot_eval u_eval (
    .rec (rdata),
    .res (ev)
  );

  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == ptet_pkg::S_IDLE) && out_free;
  assign req_acc   = req.valid && req.ready;
  assign in_range  = (32'(req.slot) < 32'(NUM_SLOTS));
  assign proc_last = (proc_idx == IW'(NUM_SLOTS - 1));

  assign fire_rep = active[proc_idx] && ev.fire && (nrep < NW'(ptet_pkg::MAX_RESULTS));
  assign stall    = fire_rep && pend_valid && !out_free;
  assign step     = (state == ptet_pkg::S_SCAN) && !stall;

  always_comb begin
    cur_res            = '0;
    cur_res.fired      = 1'b1;
    cur_res.fired_slot = 4'(proc_idx);
    cur_res.dest       = rdata.dest;
    cur_res.message    = rdata.message;
    ack_res            = '0;
    ack_res.last       = 1'b1;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ptet_pkg::S_IDLE: begin
        if (req_acc && (ptet_pkg::action_t'(req.action) == ptet_pkg::ACT_TICK)) begin
          state_next = ptet_pkg::S_SCAN;
        end
      end
      ptet_pkg::S_SCAN: begin
        if (step && proc_last) begin
          state_next = ptet_pkg::S_FLUSH;
        end
      end
      ptet_pkg::S_FLUSH: begin
        if (out_free) begin
          state_next = ptet_pkg::S_IDLE;
        end
      end
      default: state_next = ptet_pkg::S_IDLE;
    endcase
  end

  // memory reads and output register loads
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = '0;
    out_load = 1'b0;
    out_next = ack_res;
    unique case (state)
      ptet_pkg::S_IDLE: begin
        if (req_acc) begin
          if (ptet_pkg::action_t'(req.action) == ptet_pkg::ACT_TICK) begin
            rd_en = 1'b1;
          end else begin
            out_load = 1'b1;
          end
        end
      end
      ptet_pkg::S_SCAN: begin
        if (step && !proc_last) begin
          rd_en   = 1'b1;
          rd_addr = proc_idx + IW'(1);
        end
        if (step && fire_rep && pend_valid) begin
          out_load      = 1'b1;
          out_next      = pend;
          out_next.last = 1'b0;
        end
      end
      ptet_pkg::S_FLUSH: begin
        if (out_free) begin
          out_load = 1'b1;
          if (pend_valid) begin
            out_next      = pend;
            out_next.last = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
    if (state == ptet_pkg::S_IDLE && req_acc && in_range &&
        ptet_pkg::action_t'(req.action) == ptet_pkg::ACT_ADD) begin
      mem[IW'(req.slot)] <= '{one_shot: req.one_shot, period: req.period, count: 32'd0,
                              dest: req.dest_id, message: req.message_id};
    end else if (step && active[proc_idx]) begin
      mem[proc_idx] <= ev.rec_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ptet_pkg::S_IDLE;
      active     <= '0;
      proc_idx   <= '0;
      nrep       <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ptet_pkg::S_IDLE && req_acc) begin
        proc_idx   <= '0;
        nrep       <= '0;
        pend_valid <= 1'b0;
        case (ptet_pkg::action_t'(req.action))
          ptet_pkg::ACT_ADD: begin
            if (in_range) active[IW'(req.slot)] <= 1'b1;
          end
          ptet_pkg::ACT_DISABLE: begin
            if (in_range) active[IW'(req.slot)] <= 1'b0;
          end
          default: ;
        endcase
      end
      if (step) begin
        if (!proc_last) begin
          proc_idx <= proc_idx + IW'(1);
        end
        if (active[proc_idx]) begin
          active[proc_idx] <= ev.keep_active;
        end
        if (fire_rep) begin
          pend_valid <= 1'b1;
          nrep       <= nrep + NW'(1);
        end
      end
      if (state == ptet_pkg::S_FLUSH && out_free) begin
        pend_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (step && fire_rep) begin
      pend <= cur_res;
    end
    if (out_load) begin
      out_res <= out_next;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.fired       = out_res.fired;
  assign rsp.fired_slot  = out_res.fired_slot;
  assign rsp.out_dest    = out_res.dest;
  assign rsp.out_message = out_res.message;
  assign rsp.last        = out_res.last;

endmodule

// ----- design/ptet_slot_eval.sv -----
// Tick update of one slot record read from the slot memory.
// Depends on ptet_pkg.
module ptet_slot_eval (
  input  ptet_pkg::slot_rec_t  rec,
  output ptet_pkg::slot_eval_t res
);

  logic [31:0] count_inc;

  // wraps like the 32-bit counter it models; period zero always fires
  assign count_inc = rec.count + 32'd1;

  always_comb begin
    res.fire           = (count_inc >= rec.period);
    res.keep_active    = !(res.fire && (rec.one_shot == ptet_pkg::EVT_SINGLE));
    res.rec_next       = rec;
    res.rec_next.count = res.fire ? 32'd0 : count_inc;
  end

endmodule

// ----- tb/periodic_oneshot_event_timer_test.sv -----
// Self-checking bench for periodic_oneshot_event_timer: a short scripted run, then random
// add / disable / tick traffic checked against a timer-table predictor, with random stalls.
// Depends on ptet_pkg, ptet_if and the periodic_oneshot_event_timer RTL.
module periodic_oneshot_event_timer_test;

  localparam int NUM_SLOTS = ptet_pkg::NUM_SLOTS_DEF;
  localparam int RANDOM_ITEMS = 310;
  localparam int QUIET_LIMIT = 3000;
  localparam int TAIL_CYCLES = 2 * NUM_SLOTS + 8;
  localparam int IDLE_PCT = 29;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic EVT_REPEAT = ~ptet_pkg::EVT_SINGLE;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  slot;
    logic [31:0] period;
    logic        one_shot;
    logic [7:0]  dest;
    logic [15:0] msg;
  } timer_req_t;

  typedef struct {
    timer_req_t req;
    bit         ack_only;
  } script_row_t;

  localparam ptet_pkg::res_t ACK_RES = '{fired: 1'b0, fired_slot: 4'd0, dest: 8'd0,
                                         message: 16'd0, last: 1'b1};

  // ack_only rows expect the fixed acknowledgement; the rest take theirs from the predictor
  script_row_t script [21] = '{
    '{'{ptet_pkg::ACT_TICK,    4'd0,  32'd0,         EVT_REPEAT, 8'h00, 16'h0000}, 1'b1},
    '{'{ptet_pkg::ACT_DISABLE, 4'd5,  32'd0,         EVT_REPEAT, 8'h00, 16'h0000}, 1'b1},
    '{'{ACT_UNUSED,  4'd15, 32'hFFFF_FFFF, ptet_pkg::EVT_SINGLE, 8'hFF, 16'hFFFF}, 1'b1},
    '{'{ptet_pkg::ACT_ADD,     4'd0,  32'd0,         EVT_REPEAT, 8'h00, 16'h0000}, 1'b1},
    '{'{ptet_pkg::ACT_ADD, 4'd15, 32'd1, ptet_pkg::EVT_SINGLE, 8'hFF, 16'hFFFF}, 1'b1},
    '{'{ptet_pkg::ACT_ADD,     4'd7,  32'd3,         EVT_REPEAT, 8'hA5, 16'h5A5A}, 1'b1},
    '{'{ptet_pkg::ACT_ADD,     4'd3,  32'hFFFF_FFFF, EVT_REPEAT, 8'h12, 16'h3456}, 1'b1},
    '{'{ptet_pkg::ACT_TICK,    4'd0,  32'd0,         EVT_REPEAT, 8'h00, 16'h0000}, 1'b0},
    '{'{ptet_pkg::ACT_TICK,    4'd0,  32'd0,         EVT_REPEAT, 8'h00, 16'h0000}, 1'b0},
    '{'{ptet_pkg::ACT_TICK,    4'd0,  32'd0,         EVT_REPEAT, 8'h00, 16'h0000}, 1'b0},
    '{'{ptet_pkg::ACT_ADD, 4'd7, 32'd2, ptet_pkg::EVT_SINGLE, 8'h77, 16'h7777}, 1'b1},
    '{'{ptet_pkg::ACT_TICK,    4'd0,  32'd0,         EVT_REPEAT, 8'h00, 16'h0000}, 1'b0},
    '{'{ptet_pkg::ACT_TICK,    4'd0,  32'd0,         EVT_REPEAT, 8'h00, 16'h0000}, 1'b0},
    '{'{ptet_pkg::ACT_DISABLE, 4'd0,  32'd0,         EVT_REPEAT, 8'h00, 16'h0000}, 1'b1},
    '{'{ptet_pkg::ACT_DISABLE, 4'd3,  32'd0,         EVT_REPEAT, 8'h00, 16'h0000}, 1'b1},
    '{'{ptet_pkg::ACT_DISABLE, 4'd3,  32'd0,         EVT_REPEAT, 8'h00, 16'h0000}, 1'b1},
    '{'{ptet_pkg::ACT_TICK,    4'd0,  32'd0,         EVT_REPEAT, 8'h00, 16'h0000}, 1'b0},
    '{'{ptet_pkg::ACT_ADD, 4'd1, 32'd0, ptet_pkg::EVT_SINGLE, 8'h3C, 16'hC3C3}, 1'b1},
    '{'{ptet_pkg::ACT_ADD,     4'd2,  32'd0,         EVT_REPEAT, 8'hC3, 16'h3C3C}, 1'b1},
    '{'{ptet_pkg::ACT_TICK,    4'd0,  32'd0,         EVT_REPEAT, 8'h00, 16'h0000}, 1'b0},
    '{'{ptet_pkg::ACT_TICK,    4'd0,  32'd0,         EVT_REPEAT, 8'h00, 16'h0000}, 1'b0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  ptet_req_if req_ch ();
  ptet_rsp_if rsp_ch ();

  periodic_oneshot_event_timer #(.NUM_SLOTS(NUM_SLOTS)) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // timer table as the predictor sees it
  ptet_pkg::slot_rec_t timer_slot [NUM_SLOTS];
  logic                timer_live [NUM_SLOTS];
  ptet_pkg::res_t      fresh_res [ptet_pkg::MAX_RESULTS];
  ptet_pkg::res_t      pending_results [$];

  bit no_idle = 1'b0;
  int fail_count = 0;
  int quiet_cycles = 0;

  // applies one item to the table; returns how many results it yields
  function automatic int step_timer_table(input timer_req_t item);
    int n;
    n = 0;
    case (item.action)
      ptet_pkg::ACT_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (timer_live[i]) begin
            timer_slot[i].count = timer_slot[i].count + 32'd1;
            if (timer_slot[i].count >= timer_slot[i].period) begin
              timer_slot[i].count = '0;
              if (n < ptet_pkg::MAX_RESULTS) begin
                fresh_res[n] = '{fired: 1'b1, fired_slot: 4'(i), dest: timer_slot[i].dest,
                                 message: timer_slot[i].message, last: 1'b0};
                n++;
              end
              if (timer_slot[i].one_shot == ptet_pkg::EVT_SINGLE) timer_live[i] = 1'b0;
            end
          end
        end
      end
      ptet_pkg::ACT_ADD: begin
        if (int'(item.slot) < NUM_SLOTS) begin
          timer_slot[item.slot] = '{one_shot: item.one_shot, period: item.period,
                                    count: 32'd0, dest: item.dest, message: item.msg};
          timer_live[item.slot] = 1'b1;
        end
      end
      ptet_pkg::ACT_DISABLE: begin
        if (int'(item.slot) < NUM_SLOTS) timer_live[item.slot] = 1'b0;
      end
      default: ;
    endcase
    if (n > 0) begin
      fresh_res[n-1].last = 1'b1;
    end else begin
      fresh_res[0] = ACK_RES;
      n = 1;
    end
    return n;
  endfunction

  function automatic timer_req_t pick_timer_req();
    timer_req_t item;
    int roll;
    item = '{action: ptet_pkg::ACT_TICK, slot: 4'($urandom), period: $urandom,
             one_shot: 1'($urandom), dest: 8'($urandom), msg: 16'($urandom)};
    roll = $urandom_range(99);
    if (roll < 45) begin
      item.action = ptet_pkg::ACT_TICK;
    end else if (roll < 80) begin
      item.action = ptet_pkg::ACT_ADD;
      // mostly short periods so slots actually fire
      roll = $urandom_range(99);
      if (roll < 55) item.period = $urandom_range(4);
      else if (roll < 90) item.period = $urandom_range(24, 5);
    end else if (roll < 95) begin
      item.action = ptet_pkg::ACT_DISABLE;
    end else begin
      item.action = ACT_UNUSED;
    end
    return item;
  endfunction

  // called just after a rising edge; returns just after the edge that takes the item
  task automatic issue_timer_req(input timer_req_t item, input bit ack_only);
    int n;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.action     <= item.action;
    req_ch.slot       <= item.slot;
    req_ch.period     <= item.period;
    req_ch.one_shot   <= item.one_shot;
    req_ch.dest_id    <= item.dest;
    req_ch.message_id <= item.msg;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    n = step_timer_table(item);
    if (ack_only) begin
      pending_results.push_back(ACK_RES);
    end else begin
      for (int i = 0; i < n; i++) pending_results.push_back(fresh_res[i]);
    end
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  initial begin : stimulus
    req_ch.valid      = 1'b0;
    req_ch.action     = ptet_pkg::ACT_TICK;
    req_ch.slot       = '0;
    req_ch.period     = '0;
    req_ch.one_shot   = EVT_REPEAT;
    req_ch.dest_id    = '0;
    req_ch.message_id = '0;
    for (int i = 0; i < NUM_SLOTS; i++) timer_live[i] = 1'b0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) issue_timer_req(script[i].req, script[i].ack_only);
    drain_results();

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      no_idle = (k >= 140 && k < 200);
      if (k == 170) drain_results();
      issue_timer_req(pick_timer_req(), 1'b0);
    end
    no_idle = 1'b0;

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("[periodic_oneshot_event_timer] OK");
    end else begin
      $display("[periodic_oneshot_event_timer] ERROR");
    end
    $finish;
  end

  initial begin : rsp_stall
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    ptet_pkg::res_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: slot %0d", rsp_ch.fired_slot);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("fired", want.fired, rsp_ch.fired);
        check_field("fired_slot", want.fired_slot, rsp_ch.fired_slot);
        check_field("out_dest", want.dest, rsp_ch.out_dest);
        check_field("out_message", want.message, rsp_ch.out_message);
        check_field("last", want.last, rsp_ch.last);
      end
    end
  end

  // ends a hung run: too long with no item moving on either side
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[periodic_oneshot_event_timer] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
